### rtl/ddt_pkg.sv
// ----------------------------------------------------------------------------
// ddt_pkg
// Shared types and constants for the discovered device table: transaction
// payloads, stored record layout, register indexes and controller links.
// ----------------------------------------------------------------------------
package ddt_pkg;

	// Operation codes carried by a request transaction
	localparam logic OP_LOOKUP = 1'b0;
	localparam logic OP_ADD    = 1'b1;

	// Configuration register indexes and port widths
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 5;
	localparam logic [CFG_IDX_W-1:0] CFG_IGNORE_ORDER  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_IGNORE_IP     = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_IGNORE_MAC    = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_LIST_CAPACITY = 2'd3;
	localparam logic [4:0]           CAPACITY_RESET    = 5'd16;

	// Result codes
	typedef enum logic [1:0] {
		OUT_FOUND     = 2'd0,
		OUT_NOT_FOUND = 2'd1,
		OUT_ADDED     = 2'd2,
		OUT_FULL      = 2'd3
	} ddt_outcome_t;

	// Request payload
	typedef struct packed {
		logic        opcode;
		logic [15:0] device_type;
		logic [31:0] serial_number;
		logic [31:0] ip_addr;
		logic        ip_valid;
		logic [47:0] mac_addr;
		logic        mac_valid;
		logic [15:0] order_article_one;
		logic [15:0] order_article_two;
		logic [15:0] order_revision;
		logic        order_valid;
	} ddt_req_t;

	// Response payload
	typedef struct packed {
		ddt_outcome_t outcome;
		logic [3:0]   entry_index;
	} ddt_rsp_t;

	// Stored record; an absent field keeps its data bits at zero
	typedef struct packed {
		logic [47:0] type_serial;
		logic [32:0] ip;
		logic [48:0] mac;
		logic [48:0] order;
	} ddt_entry_t;

	// Controller to datapath commands
	typedef struct packed {
		logic load;
		logic exec_add;
		logic scan_clear;
		logic scan_step;
		logic set_found;
		logic set_not_found;
		logic out_load;
	} ddt_cmd_t;

	// Datapath to controller status
	typedef struct packed {
		logic is_add;
		logic empty;
		logic hit;
		logic last;
	} ddt_status_t;

endpackage

### rtl/ddt_stream_if.sv
// ----------------------------------------------------------------------------
// ddt_stream_if
// Valid/ready channel carrying one payload per transaction.
// ----------------------------------------------------------------------------
interface ddt_stream_if #(
	parameter type payload_t = logic
);
	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

### rtl/discovered_device_table.sv
// ----------------------------------------------------------------------------
// discovered_device_table
// Table of discovered device records with first-match lookup and append.
// ----------------------------------------------------------------------------
// One transaction is worked on at a time; the next request is taken while a
// finished result still waits in the output register. A lookup reads one
// stored record per cycle from the single read port of the record store and
// stops at the first hit or after the last filled entry; on an empty table it
// answers without a scan. The store needs no clearing pass after reset: only
// entries below the fill count are ever read.
module discovered_device_table #(
	parameter int TABLE_DEPTH = 16
) (
	input logic                           clk,
	input logic                           arst_n,
	ddt_stream_if.sink                    req,
	ddt_stream_if.source                  rsp,
	input logic                           cfg_we,
	input logic [ddt_pkg::CFG_IDX_W-1:0]  cfg_index,
	input logic [ddt_pkg::CFG_DATA_W-1:0] cfg_data
);
	ddt_pkg::ddt_cmd_t    cmd;
	ddt_pkg::ddt_status_t status;
	ddt_pkg::ddt_req_t    req_data;
	ddt_pkg::ddt_rsp_t    rsp_data;

	assign req_data = req.data;
	assign rsp.data = rsp_data;

	ddt_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req.ready),
		.rsp_valid (rsp.valid),
		.rsp_ready (rsp.ready),
		.status    (status),
		.cmd       (cmd)
	);

	ddt_datapath #(
		.TABLE_DEPTH (TABLE_DEPTH)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.req_data  (req_data),
		.cmd       (cmd),
		.status    (status),
		.rsp_data  (rsp_data)
	);

endmodule

### rtl/ddt_datapath.sv
// ----------------------------------------------------------------------------
// ddt_datapath
// Record store, configuration registers, fill count, scan pointer, match
// logic and the result / output registers.
// ----------------------------------------------------------------------------
module ddt_datapath #(
	parameter int TABLE_DEPTH = 16
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [ddt_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [ddt_pkg::CFG_DATA_W-1:0] cfg_data,
	input  ddt_pkg::ddt_req_t              req_data,
	input  ddt_pkg::ddt_cmd_t              cmd,
	output ddt_pkg::ddt_status_t           status,
	output ddt_pkg::ddt_rsp_t              rsp_data
);
	localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
	localparam int CMP_W = (CNT_W > ddt_pkg::CFG_DATA_W) ? CNT_W : ddt_pkg::CFG_DATA_W;

	// Configuration registers
	logic       ign_order_q;
	logic       ign_ip_q;
	logic       ign_mac_q;
	logic [4:0] capacity_q;

	// Current item
	logic               op_q;
	ddt_pkg::ddt_entry_t key_q;
	ddt_pkg::ddt_entry_t key_c;

	// Fill count, scan pointer and read stage
	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] rd_idx_q;
	logic             rdv_s1;
	logic [IDX_W-1:0] idx_s1;
	logic [CNT_W-1:0] idx_next_c;
	ddt_pkg::ddt_entry_t rd_data_s1;
	ddt_pkg::ddt_entry_t entries_q [TABLE_DEPTH];

	// Result registers
	ddt_pkg::ddt_outcome_t res_outcome_q;
	logic [IDX_W-1:0]      res_index_q;
	logic [IDX_W+3:0]      res_index_wide;
	ddt_pkg::ddt_rsp_t     rsp_q;

	logic [CMP_W-1:0] cap_ext;
	logic [CMP_W-1:0] cap_eff;
	logic             room;
	logic             rd_more;
	logic             match;

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ign_order_q <= 1'b0;
			ign_ip_q    <= 1'b0;
			ign_mac_q   <= 1'b0;
			capacity_q  <= ddt_pkg::CAPACITY_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				ddt_pkg::CFG_IGNORE_ORDER:  ign_order_q <= cfg_data[0];
				ddt_pkg::CFG_IGNORE_IP:     ign_ip_q    <= cfg_data[0];
				ddt_pkg::CFG_IGNORE_MAC:    ign_mac_q   <= cfg_data[0];
				ddt_pkg::CFG_LIST_CAPACITY: capacity_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// Normalise the incoming record: absent fields get zero data bits
	always_comb begin
		key_c.type_serial = {req_data.device_type, req_data.serial_number};
		key_c.ip    = req_data.ip_valid  ? {1'b1, req_data.ip_addr}  : '0;
		key_c.mac   = req_data.mac_valid ? {1'b1, req_data.mac_addr} : '0;
		key_c.order = req_data.order_valid
			? {1'b1, req_data.order_article_one, req_data.order_article_two,
			   req_data.order_revision}
			: '0;
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q  <= req_data.opcode;
			key_q <= key_c;
		end
	end

	// Effective capacity is the smaller of the register and the depth
	assign cap_ext = CMP_W'(capacity_q);
	assign cap_eff = (cap_ext < CMP_W'(TABLE_DEPTH)) ? cap_ext : CMP_W'(TABLE_DEPTH);
	assign room    = CMP_W'(count_q) < cap_eff;
	assign rd_more = rd_idx_q < count_q;

	// Record compare against the registered read data
	assign match = (rd_data_s1.type_serial == key_q.type_serial)
		&& (ign_ip_q    || (rd_data_s1.ip    == key_q.ip))
		&& (ign_mac_q   || (rd_data_s1.mac   == key_q.mac))
		&& (ign_order_q || (rd_data_s1.order == key_q.order));

	assign idx_next_c = CNT_W'(idx_s1) + CNT_W'(1);

	assign status.is_add = (op_q == ddt_pkg::OP_ADD);
	assign status.empty  = (count_q == '0);
	assign status.hit    = rdv_s1 && match;
	assign status.last   = rdv_s1 && (idx_next_c == count_q);

	// Record store: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (cmd.exec_add && room) begin
			entries_q[count_q[IDX_W-1:0]] <= key_q;
		end
		if (cmd.scan_step && rd_more) begin
			rd_data_s1 <= entries_q[rd_idx_q[IDX_W-1:0]];
		end
	end

	// Fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (cmd.exec_add && room) begin
			count_q <= count_q + CNT_W'(1);
		end
	end

	// Scan pointer and read-stage tag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_idx_q <= '0;
			rdv_s1   <= 1'b0;
			idx_s1   <= '0;
		end else if (cmd.scan_clear) begin
			rd_idx_q <= '0;
			rdv_s1   <= 1'b0;
		end else if (cmd.scan_step) begin
			if (rd_more) begin
				rd_idx_q <= rd_idx_q + CNT_W'(1);
				rdv_s1   <= 1'b1;
				idx_s1   <= rd_idx_q[IDX_W-1:0];
			end else begin
				rdv_s1   <= 1'b0;
			end
		end
	end

	// Result capture
	always_ff @(posedge clk) begin
		if (cmd.exec_add) begin
			if (room) begin
				res_outcome_q <= ddt_pkg::OUT_ADDED;
				res_index_q   <= count_q[IDX_W-1:0];
			end else begin
				res_outcome_q <= ddt_pkg::OUT_FULL;
				res_index_q   <= '0;
			end
		end else if (cmd.set_found) begin
			res_outcome_q <= ddt_pkg::OUT_FOUND;
			res_index_q   <= idx_s1;
		end else if (cmd.set_not_found) begin
			res_outcome_q <= ddt_pkg::OUT_NOT_FOUND;
			res_index_q   <= '0;
		end
	end

	// Output register, low four bits of the index
	assign res_index_wide = {4'b0000, res_index_q};

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			rsp_q.outcome     <= res_outcome_q;
			rsp_q.entry_index <= res_index_wide[3:0];
		end
	end

	assign rsp_data = rsp_q;

endmodule

### rtl/ddt_ctrl.sv
// ----------------------------------------------------------------------------
// ddt_ctrl
// Sequencer for one transaction at a time: take the item, append or scan (a lookup
// on an empty table skips the scan), then hand the result to the output register.
// ----------------------------------------------------------------------------
module ddt_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 req_valid,
	output logic                 req_ready,
	output logic                 rsp_valid,
	input  logic                 rsp_ready,
	input  ddt_pkg::ddt_status_t status,
	output ddt_pkg::ddt_cmd_t    cmd
);
	typedef enum logic [3:0] {
		S_IDLE = 4'b0001,
		S_EXEC = 4'b0010,
		S_SCAN = 4'b0100,
		S_DONE = 4'b1000
	} state_t;

	state_t state_q;
	state_t state_nxt;
	logic   rsp_valid_q;
	logic   out_free;

	assign out_free  = !rsp_valid_q || rsp_ready;
	assign req_ready = (state_q == S_IDLE);
	assign rsp_valid = rsp_valid_q;

	// Next state and commands
	always_comb begin
		state_nxt = state_q;
		cmd       = '0;
		case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					cmd.load  = 1'b1;
					state_nxt = S_EXEC;
				end
			end
			S_EXEC: begin
				if (status.is_add) begin
					cmd.exec_add = 1'b1;
					state_nxt    = S_DONE;
				end else if (status.empty) begin
					cmd.set_not_found = 1'b1;
					state_nxt         = S_DONE;
				end else begin
					cmd.scan_clear = 1'b1;
					state_nxt      = S_SCAN;
				end
			end
			S_SCAN: begin
				cmd.scan_step = 1'b1;
				if (status.hit) begin
					cmd.set_found = 1'b1;
					state_nxt     = S_DONE;
				end else if (status.last) begin
					cmd.set_not_found = 1'b1;
					state_nxt         = S_DONE;
				end
			end
			S_DONE: begin
				if (out_free) begin
					cmd.out_load = 1'b1;
					state_nxt    = S_IDLE;
				end
			end
			default: begin
				state_nxt = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	// Output register occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

endmodule

### rtl/ddt_checker.sv
// ----------------------------------------------------------------------------
// ddt_checker
// Port-level checks on the discovered device table, bound to the top level.
// ----------------------------------------------------------------------------
module ddt_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              req_valid,
	input logic              req_ready,
	input logic              rsp_valid,
	input logic              rsp_ready,
	input ddt_pkg::ddt_rsp_t rsp_data
);
	logic       req_acc;
	logic       rsp_acc;
	logic [2:0] inflight_q;

	assign req_acc = req_valid && req_ready;
	assign rsp_acc = rsp_valid && rsp_ready;

	// Transactions taken but not yet answered
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inflight_q <= '0;
		end else begin
			inflight_q <= inflight_q + 3'(req_acc) - 3'(rsp_acc);
		end
	end

	// A stalled response holds
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
		else $error("response changed while stalled");

	// Miss and full carry index zero
	a_idx_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (rsp_data.outcome == ddt_pkg::OUT_NOT_FOUND ||
			rsp_data.outcome == ddt_pkg::OUT_FULL) |-> rsp_data.entry_index == 4'd0)
		else $error("non-zero index on miss or full");

	// One item in work: no request taken in the cycle after one is accepted
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		req_acc |=> !req_ready)
		else $error("request accepted while busy");

	// At most one item in work plus one in the output register
	a_depth: assert property (@(posedge clk) disable iff (!arst_n)
		inflight_q <= 3'd2)
		else $error("too many transactions outstanding");

	// No response without a request
	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		inflight_q == 3'd0 |-> !rsp_valid)
		else $error("response without request");

endmodule

bind discovered_device_table ddt_checker u_ddt_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_valid (req.valid),
	.req_ready (req.ready),
	.rsp_valid (rsp.valid),
	.rsp_ready (rsp.ready),
	.rsp_data  (rsp.data)
);

### tb/sv/ddt_table_monitor.sv
// ----------------------------------------------------------------------------
// ddt_table_monitor
// Watches the request, response and register ports of the discovered device
// table. It keeps its own copy of the records and of the registers, works out
// the outcome of every accepted request and compares each response with the
// oldest outcome still owed.
// ----------------------------------------------------------------------------
module ddt_table_monitor
	import ddt_pkg::*;
#(
	parameter int TABLE_DEPTH = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  req_valid,
	input  logic                  req_ready,
	input  ddt_req_t              req_data,
	input  logic                  rsp_valid,
	input  logic                  rsp_ready,
	input  ddt_rsp_t              rsp_data,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output int                    failures,
	output int                    pending
);
	timeunit 1ns;
	timeprecision 1ps;

	// Shadow of the record store and registers
	ddt_entry_t  shadow_entries [TABLE_DEPTH];
	int          shadow_count;
	logic        skip_order;
	logic        skip_ip;
	logic        skip_mac;
	logic [4:0]  capacity;

	ddt_rsp_t    owed_replies [$];
	int          fail_count;

	// Outcome of one request; an add also updates the shadow store
	function automatic ddt_rsp_t resolve_request(ddt_req_t r);
		ddt_entry_t key;
		ddt_rsp_t   res;
		int         limit;
		logic       hit;
		key.type_serial = {r.device_type, r.serial_number};
		key.ip    = r.ip_valid ? {1'b1, r.ip_addr} : '0;
		key.mac   = r.mac_valid ? {1'b1, r.mac_addr} : '0;
		key.order = r.order_valid
			? {1'b1, r.order_article_one, r.order_article_two, r.order_revision} : '0;
		res.outcome     = OUT_NOT_FOUND;
		res.entry_index = '0;
		if (r.opcode == OP_LOOKUP) begin
			// first filled entry that matches wins
			for (int i = 0; i < shadow_count; i++) begin
				hit = (shadow_entries[i].type_serial == key.type_serial);
				if (!skip_ip && shadow_entries[i].ip != key.ip)
					hit = 1'b0;
				if (!skip_mac && shadow_entries[i].mac != key.mac)
					hit = 1'b0;
				if (!skip_order && shadow_entries[i].order != key.order)
					hit = 1'b0;
				if (hit) begin
					res.outcome     = OUT_FOUND;
					res.entry_index = i[3:0];
					return res;
				end
			end
			return res;
		end
		// append, capacity clipped to the store depth
		limit = (capacity < TABLE_DEPTH) ? int'(capacity) : TABLE_DEPTH;
		if (shadow_count < limit) begin
			shadow_entries[shadow_count] = key;
			res.outcome     = OUT_ADDED;
			res.entry_index = shadow_count[3:0];
			shadow_count++;
		end else begin
			res.outcome = OUT_FULL;
		end
		return res;
	endfunction

	// Track registers, predict on request, compare on response
	always @(posedge clk or negedge arst_n) begin
		ddt_rsp_t want;
		if (!arst_n) begin
			owed_replies.delete();
			shadow_count = 0;
			skip_order   = 1'b0;
			skip_ip      = 1'b0;
			skip_mac     = 1'b0;
			capacity     = CAPACITY_RESET;
			fail_count   = 0;
			failures    <= 0;
			pending     <= 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_IGNORE_ORDER:  skip_order = cfg_data[0];
					CFG_IGNORE_IP:     skip_ip    = cfg_data[0];
					CFG_IGNORE_MAC:    skip_mac   = cfg_data[0];
					CFG_LIST_CAPACITY: capacity   = cfg_data[4:0];
					default: ;
				endcase
			end
			if (rsp_valid && rsp_ready) begin
				if (owed_replies.size() == 0) begin
					$display("%0t: unexpected response outcome=%0d index=%0d", $time,
						rsp_data.outcome, rsp_data.entry_index);
					fail_count++;
				end else begin
					want = owed_replies.pop_front();
					if (rsp_data.outcome !== want.outcome) begin
						$display("%0t: outcome mismatch: expected %0d, got %0d", $time,
							want.outcome, rsp_data.outcome);
						fail_count++;
					end
					if (rsp_data.entry_index !== want.entry_index) begin
						$display("%0t: entry_index mismatch: expected %0d, got %0d", $time,
							want.entry_index, rsp_data.entry_index);
						fail_count++;
					end
				end
			end
			if (req_valid && req_ready)
				owed_replies.push_back(resolve_request(req_data));
			failures <= fail_count;
			pending  <= owed_replies.size();
		end
	end

endmodule

### tb/sv/tb.sv
// ----------------------------------------------------------------------------
// tb
// Top of the discovered device table testbench. Drives directed and random
// lookup and add transactions through several register settings, with random
// gaps and stalls on both channels; the monitor checks every response.
// ----------------------------------------------------------------------------
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import ddt_pkg::*;

	localparam int          PHASES       = 11;
	localparam int          PHASE_ITEMS  = 103;
	localparam int          ADD_PCT      = 15;
	localparam int          LONG_HOLD    = 400;
	localparam int          TAIL_CYCLES  = 24;
	localparam int unsigned CYCLE_LIMIT  = 800_000;

	logic                  clk    = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	int                    failures;
	int                    pending;
	int unsigned           cycle_count = 0;
	int                    holds_asked = 0;
	bit                    steady_send = 1'b0;
	logic [47:0]           id_pool [4];
	ddt_req_t              sent_adds [$];

	ddt_stream_if #(.payload_t(ddt_req_t)) req_ch ();
	ddt_stream_if #(.payload_t(ddt_rsp_t)) rsp_ch ();

	discovered_device_table i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req_ch),
		.rsp       (rsp_ch),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	ddt_table_monitor i_monitor (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_ch.valid),
		.req_ready (req_ch.ready),
		.req_data  (req_ch.data),
		.rsp_valid (rsp_ch.valid),
		.rsp_ready (rsp_ch.ready),
		.rsp_data  (rsp_ch.data),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.failures  (failures),
		.pending   (pending)
	);

	always #5ns clk = ~clk;

	// Run limit
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("discovered_device_table verification failed");
			$finish;
		end
	end

	// Gap before a request: mostly none or short, now and then long
	function automatic int pick_gap();
		int roll;
		if (steady_send)
			return 0;
		roll = $urandom_range(0, 99);
		if (roll < 55)
			return 0;
		if (roll < 85)
			return $urandom_range(1, 3);
		if (roll < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic ddt_req_t pack_record(logic op, logic [47:0] id,
			logic ipv, logic [31:0] ip, logic macv, logic [47:0] mac,
			logic ordv, logic [47:0] ord);
		ddt_req_t r;
		r.opcode = op;
		{r.device_type, r.serial_number} = id;
		r.ip_valid  = ipv;
		r.ip_addr   = ip;
		r.mac_valid = macv;
		r.mac_addr  = mac;
		{r.order_article_one, r.order_article_two, r.order_revision} = ord;
		r.order_valid = ordv;
		return r;
	endfunction

	// Record with a mostly shared type/serial so that entries collide
	function automatic ddt_req_t random_record(logic op);
		logic [47:0] id;
		if ($urandom_range(0, 4) != 0)
			id = id_pool[$urandom_range(0, 3)];
		else
			id = {16'($urandom), $urandom};
		return pack_record(op, id,
			$urandom_range(0, 3) != 0, $urandom,
			$urandom_range(0, 3) != 0, {16'($urandom), $urandom},
			$urandom_range(0, 3) != 0, {16'($urandom), 16'($urandom), 16'($urandom)});
	endfunction

	// Lookup built from an earlier add: exact, with one field disturbed, or with absent data bits changed
	function automatic ddt_req_t probe_from(ddt_req_t base);
		ddt_req_t p;
		int       bitpos;
		p        = base;
		p.opcode = OP_LOOKUP;
		bitpos   = $urandom_range(0, 47);
		case ($urandom_range(0, 15))
			0: p.serial_number[bitpos % 32] = ~p.serial_number[bitpos % 32];
			1: p.device_type[bitpos % 16] = ~p.device_type[bitpos % 16];
			2: p.ip_addr[bitpos % 32] = ~p.ip_addr[bitpos % 32];
			3: p.mac_addr[bitpos] = ~p.mac_addr[bitpos];
			4: p.order_article_one[bitpos % 16] = ~p.order_article_one[bitpos % 16];
			5: p.order_article_two[bitpos % 16] = ~p.order_article_two[bitpos % 16];
			6: p.order_revision[bitpos % 16] = ~p.order_revision[bitpos % 16];
			7: p.ip_valid = ~p.ip_valid;
			8: p.mac_valid = ~p.mac_valid;
			9: p.order_valid = ~p.order_valid;
			10: begin
				// data bits of absent values must not matter
				if (!p.ip_valid)
					p.ip_addr = $urandom;
				if (!p.mac_valid)
					p.mac_addr = {16'($urandom), $urandom};
				if (!p.order_valid)
					{p.order_article_one, p.order_article_two, p.order_revision} =
						{16'($urandom), 16'($urandom), 16'($urandom)};
			end
			default: ;
		endcase
		return p;
	endfunction

	// Stored entries are among the earliest adds, so probe those mostly
	function automatic ddt_req_t pick_stored();
		int span;
		span = (sent_adds.size() < 20) ? sent_adds.size() : 20;
		if ($urandom_range(0, 9) == 0)
			span = sent_adds.size();
		return sent_adds[$urandom_range(0, span - 1)];
	endfunction

	function automatic ddt_req_t next_random_item();
		ddt_req_t r;
		if ($urandom_range(0, 99) < ADD_PCT) begin
			if (sent_adds.size() > 0 && $urandom_range(0, 3) == 0) begin
				// duplicate of an earlier record
				r = pick_stored();
				return r;
			end
			return random_record(OP_ADD);
		end
		if (sent_adds.size() > 0 && $urandom_range(0, 9) < 7)
			return probe_from(pick_stored());
		return random_record(OP_LOOKUP);
	endfunction

	// One request transaction; valid stays high when the next follows at once
	task automatic offer_request(input ddt_req_t r);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			req_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.data  <= r;
		do @(posedge clk); while (!req_ch.ready);
		if (r.opcode == OP_ADD)
			sent_adds.push_back(r);
	endtask

	// Stop offering and wait for every owed response
	task automatic settle();
		req_ch.valid <= 1'b0;
		do @(posedge clk); while (pending != 0);
		repeat (2) @(posedge clk);
	endtask

	// Writes all four registers on consecutive edges
	task automatic program_regs(logic skip_ord, logic skip_ip, logic skip_mac,
			logic [4:0] cap);
		cfg_we    <= 1'b1;
		cfg_index <= CFG_IGNORE_ORDER;
		cfg_data  <= {4'($urandom), skip_ord};
		@(posedge clk);
		cfg_index <= CFG_IGNORE_IP;
		cfg_data  <= {4'($urandom), skip_ip};
		@(posedge clk);
		cfg_index <= CFG_IGNORE_MAC;
		cfg_data  <= {4'($urandom), skip_mac};
		@(posedge clk);
		cfg_index <= CFG_LIST_CAPACITY;
		cfg_data  <= cap;
		@(posedge clk);
		cfg_we    <= 1'b0;
	endtask

	// Response side: random stalls, long ready runs and the requested hold-off
	initial begin : reply_acceptor
		int holds_served;
		int roll;
		holds_served = 0;
		rsp_ch.ready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (holds_served != holds_asked) begin
				holds_served++;
				rsp_ch.ready <= 1'b0;
				repeat (LONG_HOLD) @(posedge clk);
			end else begin
				roll = $urandom_range(0, 99);
				if (roll < 20) begin
					rsp_ch.ready <= 1'b0;
					repeat ($urandom_range(1, 3)) @(posedge clk);
				end else if (roll < 25) begin
					rsp_ch.ready <= 1'b0;
					repeat ($urandom_range(10, 60)) @(posedge clk);
				end else if (roll < 30) begin
					rsp_ch.ready <= 1'b1;
					repeat ($urandom_range(100, 300)) @(posedge clk);
				end else begin
					rsp_ch.ready <= 1'b1;
					repeat ($urandom_range(1, 12)) @(posedge clk);
				end
			end
		end
	end

	// Stimulus
	initial begin : request_source
		ddt_req_t   rec_a;
		ddt_req_t   rec_b;
		ddt_req_t   rec_c;
		ddt_req_t   q;
		logic [4:0] cap;
		req_ch.valid <= 1'b0;
		req_ch.data  <= '0;
		cfg_we       <= 1'b0;
		cfg_index    <= CFG_IGNORE_ORDER;
		cfg_data     <= '0;
		id_pool[0] = '1;
		id_pool[1] = '0;
		id_pool[2] = {16'($urandom), $urandom};
		id_pool[3] = {16'($urandom), $urandom};
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// lookup on an empty table at reset settings
		offer_request(pack_record(OP_LOOKUP, '1, 1'b1, '1, 1'b1, '1, 1'b1, '1));

		// zero capacity: add is refused
		settle();
		program_regs(1'b0, 1'b0, 1'b0, 5'd0);
		offer_request(random_record(OP_ADD));

		// fill a three entry table: all ones, all zeros, all absent
		settle();
		program_regs(1'b0, 1'b0, 1'b0, 5'd3);
		rec_a = pack_record(OP_ADD, '1, 1'b1, '1, 1'b1, '1, 1'b1, '1);
		rec_b = pack_record(OP_ADD, '0, 1'b1, '0, 1'b1, '0, 1'b1, '0);
		rec_c = pack_record(OP_ADD, '1, 1'b0, 32'h5A5A_A5A5, 1'b0, 48'h0123_4567_89AB,
			1'b0, 48'hFEDC_BA98_7654);
		offer_request(rec_a);
		offer_request(rec_b);
		offer_request(rec_c);
		offer_request(random_record(OP_ADD));

		// exact hits, absent data ignored, single field misses
		q = rec_a; q.opcode = OP_LOOKUP;
		offer_request(q);
		q = rec_b; q.opcode = OP_LOOKUP;
		offer_request(q);
		q = rec_c; q.opcode = OP_LOOKUP;
		q.ip_addr = ~q.ip_addr; q.mac_addr = ~q.mac_addr; q.order_revision = '0;
		offer_request(q);
		q = rec_a; q.opcode = OP_LOOKUP; q.ip_valid = 1'b0;
		offer_request(q);
		q = rec_a; q.opcode = OP_LOOKUP; q.ip_addr[0] = 1'b0;
		offer_request(q);
		q = rec_a; q.opcode = OP_LOOKUP; q.mac_addr[47] = 1'b0;
		offer_request(q);
		q = rec_a; q.opcode = OP_LOOKUP; q.order_article_two[7] = 1'b0;
		offer_request(q);

		// everything optional ignored, capacity above depth, duplicate add
		settle();
		program_regs(1'b1, 1'b1, 1'b1, 5'd31);
		q = random_record(OP_LOOKUP); {q.device_type, q.serial_number} = '1;
		offer_request(q);
		q = random_record(OP_LOOKUP); {q.device_type, q.serial_number} = '0;
		offer_request(q);
		offer_request(rec_a);
		q = rec_a; q.opcode = OP_LOOKUP; q.serial_number[31] = 1'b0;
		offer_request(q);

		// order number ignored only
		settle();
		program_regs(1'b1, 1'b0, 1'b0, 5'd16);
		q = rec_c; q.opcode = OP_LOOKUP; q.order_valid = 1'b1;
		offer_request(q);
		q = rec_b; q.opcode = OP_LOOKUP; q.order_valid = 1'b0;
		offer_request(q);

		// capacity below the fill count: add refused, lookup still scans all
		settle();
		program_regs(1'b0, 1'b1, 1'b0, 5'd2);
		offer_request(random_record(OP_ADD));
		q = rec_b; q.opcode = OP_LOOKUP; q.ip_addr = $urandom;
		offer_request(q);

		// MAC ignored only
		settle();
		program_regs(1'b0, 1'b0, 1'b1, 5'd16);
		q = rec_a; q.opcode = OP_LOOKUP; q.mac_valid = 1'b0;
		offer_request(q);

		// random phases, each with its own register setting
		for (int ph = 0; ph < PHASES; ph++) begin
			settle();
			if (ph < 6)
				cap = 5'($urandom_range(0, 5 + 2 * ph));
			else
				case ($urandom_range(0, 3))
					0: cap = 5'd0;
					1: cap = 5'd31;
					2: cap = 5'd16;
					default: cap = 5'($urandom_range(0, 31));
				endcase
			program_regs(1'($urandom), 1'($urandom), 1'($urandom), cap);
			steady_send = ($urandom_range(0, 3) == 0);
			if (ph == 1) begin
				// back-to-back offers against a long response hold-off
				steady_send = 1'b1;
				holds_asked++;
			end
			for (int n = 0; n < PHASE_ITEMS; n++)
				offer_request(next_random_item());
		end

		// drain and give the verdict
		req_ch.valid <= 1'b0;
		do @(posedge clk); while (pending != 0);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (failures == 0)
			$display("discovered_device_table verification clean");
		else
			$display("discovered_device_table verification failed");
		$finish;
	end

endmodule

### files.f
rtl/ddt_pkg.sv
rtl/ddt_stream_if.sv
rtl/ddt_datapath.sv
rtl/ddt_ctrl.sv
rtl/discovered_device_table.sv
rtl/ddt_checker.sv
tb/sv/ddt_table_monitor.sv
tb/sv/tb.sv
